### hdl/pfdm_pkg.sv
// ----------------------------------------------------------------------------
// pfdm_pkg: shared types and constants
// Command codes, job classes, register indexes and the config and queue
// structs used by the patch distance map core.
// ----------------------------------------------------------------------------
package pfdm_pkg;

	// Q1.15 one
	localparam logic [15:0] Q_ONE = 16'd32768;

	// input commands
	typedef enum logic [1:0] {
		CMD_WIMG  = 2'd0,
		CMD_WFEAT = 2'd1,
		CMD_EVAL  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// job classes handed from front to back
	typedef enum logic [1:0] {
		K_WIMG  = 2'd0,
		K_WFEAT = 2'd1,
		K_EVAL  = 2'd2,
		K_ERR   = 2'd3
	} kind_t;

	// register indexes
	localparam logic [2:0] CFG_SRC_WIDTH     = 3'd0;
	localparam logic [2:0] CFG_SRC_HEIGHT    = 3'd1;
	localparam logic [2:0] CFG_SRC_DEPTH     = 3'd2;
	localparam logic [2:0] CFG_PATCH_WIDTH   = 3'd3;
	localparam logic [2:0] CFG_FEATURE_COUNT = 3'd4;
	localparam logic [2:0] CFG_OUTPUT_WIDTH  = 3'd5;

	typedef struct packed {
		logic [8:0] src_width;
		logic [8:0] src_height;
		logic [4:0] src_depth;
		logic [4:0] patch_width;
		logic [6:0] feature_count;
		logic [8:0] output_width;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [15:0] value;
		logic [7:0]  cell_x;
		logic [7:0]  cell_y;
		logic [5:0]  feature_index;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

### hdl/pfdm_if.sv
// ----------------------------------------------------------------------------
// pfdm channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pfdm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [15:0] value;
	logic [7:0]  cell_x;
	logic [7:0]  cell_y;
	logic [5:0]  feature_index;

	modport source (output valid, command, address, value, cell_x, cell_y, feature_index,
		input ready);
	modport sink (input valid, command, address, value, cell_x, cell_y, feature_index,
		output ready);
endinterface

interface pfdm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] match_score;
	logic        range_error;

	modport source (output valid, match_score, range_error, input ready);
	modport sink (input valid, match_score, range_error, output ready);
endinterface

### hdl/pfdm_front.sv
// ----------------------------------------------------------------------------
// pfdm_front: command intake and classification
// Clamps write values, range checks addresses, registers and cell
// coordinates, and pushes a classified job into the queue.
// ----------------------------------------------------------------------------
module pfdm_front #(
	parameter int IMAGE_WORDS     = 65536,
	parameter int FEATURE_WORDS   = 16384,
	parameter int MAX_PATCH_WIDTH = 16,
	parameter int MAX_DEPTH       = 16
) (
	pfdm_in_if.sink           cmd_ch,
	input  pfdm_pkg::cfg_t    cfg,
	input  pfdm_pkg::fifo_stat_t stat,
	output logic              push,
	output pfdm_pkg::job_t    job
);

	logic [15:0] val_c;
	logic        img_ok, feat_ok, cfg_ok, eval_ok;

	// clamp value above one
	assign val_c = (cmd_ch.value > pfdm_pkg::Q_ONE) ? pfdm_pkg::Q_ONE : cmd_ch.value;

	assign img_ok  = 32'(cmd_ch.address) < 32'(IMAGE_WORDS);
	assign feat_ok = 32'(cmd_ch.address) < 32'(FEATURE_WORDS);

	// register ranges
	assign cfg_ok = (cfg.src_width >= 9'd1) && (cfg.src_width <= 9'd256)
		&& (cfg.src_height >= 9'd1) && (cfg.src_height <= 9'd256)
		&& (cfg.src_depth >= 5'd1) && (cfg.src_depth <= 5'd16)
		&& (32'(cfg.src_depth) <= 32'(MAX_DEPTH))
		&& (cfg.patch_width >= 5'd1) && (cfg.patch_width <= 5'd16)
		&& (32'(cfg.patch_width) <= 32'(MAX_PATCH_WIDTH))
		&& (cfg.feature_count >= 7'd1) && (cfg.feature_count <= 7'd64)
		&& (cfg.output_width >= 9'd1) && (cfg.output_width <= 9'd256);

	assign eval_ok = cfg_ok && (9'(cmd_ch.cell_x) < cfg.output_width)
		&& (9'(cmd_ch.cell_y) < cfg.output_width)
		&& (7'(cmd_ch.feature_index) < cfg.feature_count);

	assign cmd_ch.ready = !stat.full;

	// classify
	always_comb begin
		job.address       = cmd_ch.address;
		job.value         = val_c;
		job.cell_x        = cmd_ch.cell_x;
		job.cell_y        = cmd_ch.cell_y;
		job.feature_index = cmd_ch.feature_index;
		job.kind          = pfdm_pkg::K_ERR;
		push              = cmd_ch.valid && !stat.full;
		unique case (pfdm_pkg::cmd_t'(cmd_ch.command))
			pfdm_pkg::CMD_WIMG: job.kind = img_ok ? pfdm_pkg::K_WIMG : pfdm_pkg::K_ERR;
			pfdm_pkg::CMD_WFEAT: job.kind = feat_ok ? pfdm_pkg::K_WFEAT : pfdm_pkg::K_ERR;
			pfdm_pkg::CMD_EVAL: job.kind = eval_ok ? pfdm_pkg::K_EVAL : pfdm_pkg::K_ERR;
			default: push = 1'b0;
		endcase
	end

endmodule

### hdl/pfdm_fifo.sv
// ----------------------------------------------------------------------------
// pfdm_fifo: job queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module pfdm_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pfdm_pkg::job_t       din,
	input  logic                 pop,
	output pfdm_pkg::job_t       dout,
	output pfdm_pkg::fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pfdm_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign dout       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule

### hdl/pfdm_div.sv
// ----------------------------------------------------------------------------
// pfdm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfdm_div #(
	parameter int NW = 17,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fit;

	assign trial = {rem_q, num_q[NW-1]};
	assign fit   = trial >= {1'b0, den_q};
	assign quo   = num_q;
	assign rem   = rem_q;
	assign done  = done_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], fit};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1)) && !start;
			if (start)
				cnt_q <= CW'(NW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

### hdl/pfdm_back.sv
// ----------------------------------------------------------------------------
// pfdm_back: job execution
// Holds both stores, walks the sampling grid, accumulates squared
// differences, then divides by the patch size and takes the square root.
// ----------------------------------------------------------------------------
module pfdm_back #(
	parameter int IMAGE_WORDS     = 65536,
	parameter int FEATURE_WORDS   = 16384,
	parameter int MAX_PATCH_WIDTH = 16,
	parameter int MAX_DEPTH       = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfdm_pkg::cfg_t       cfg,
	input  pfdm_pkg::fifo_stat_t stat,
	input  pfdm_pkg::job_t       job,
	output logic                 pop,
	pfdm_out_if.source           res_ch
);

	localparam int IMG_AW  = $clog2(IMAGE_WORDS);
	localparam int FEAT_AW = $clog2(FEATURE_WORDS);
	localparam int GW      = (MAX_PATCH_WIDTH > 1) ? $clog2(MAX_PATCH_WIDTH) : 1;
	localparam int DW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_FS1    = 16'h0002,
		S_FS2    = 16'h0004,
		S_FB     = 16'h0008,
		S_FCHK   = 16'h0010,
		S_DSTART = 16'h0020,
		S_DWAIT  = 16'h0040,
		S_PA     = 16'h0080,
		S_PB     = 16'h0100,
		S_PC     = 16'h0200,
		S_RD     = 16'h0400,
		S_DRAIN  = 16'h0800,
		S_MSTART = 16'h1000,
		S_MWAIT  = 16'h2000,
		S_SQRT   = 16'h4000,
		S_OUT    = 16'h8000
	} bstate_t;

	bstate_t        state_q;
	pfdm_pkg::job_t job_q;
	logic           err_q;

	logic [9:0]  pw2_q;
	logic [12:0] fsize_q;
	logic [18:0] fbase_q;
	logic [2:0]  dsel_q;
	logic [8:0]  ty_q, by_q, tx_q, bx_q, qy_q, qx_q;
	logic [4:0]  ry_q, rx_q;
	logic [GW-1:0] gx_q, gy_q;
	logic [8:0]  sy_q, sx_q;
	logic [4:0]  syr_q, sxr_q;
	logic [16:0] row_q;
	logic [20:0] ia_q;
	logic [DW-1:0] d_q;
	logic [18:0] fa_q;
	logic        rd_v_s1, sq_v_s2;
	logic [15:0] img_s1, feat_s1;
	logic [30:0] sq_s2;
	logic [42:0] sum_q;
	logic [30:0] v_q, bit_q;
	logic [31:0] res_q;
	logic [3:0]  sqi_q;
	logic        out_valid_q, out_err_q;
	logic [15:0] out_score_q;

	// memory ports
	logic               img_we, feat_we, rd_en;
	logic [21:0]        wa_ext;
	logic [20:0]        ia_d;
	logic [IMG_AW-1:0]  img_wa, img_ra;
	logic [FEAT_AW-1:0] feat_wa, feat_ra;

	logic [15:0] img_mem [IMAGE_WORDS];
	logic [15:0] feat_mem [FEATURE_WORDS];

	assign pop     = (state_q == S_IDLE) && !stat.empty;
	assign img_we  = pop && (job.kind == pfdm_pkg::K_WIMG);
	assign feat_we = pop && (job.kind == pfdm_pkg::K_WFEAT);
	assign rd_en   = (state_q == S_RD);
	assign wa_ext  = 22'(job.address);
	assign img_wa  = wa_ext[IMG_AW-1:0];
	assign feat_wa = wa_ext[FEAT_AW-1:0];
	assign ia_d    = ia_q + 21'(d_q);
	assign img_ra  = ia_d[IMG_AW-1:0];
	assign feat_ra = fa_q[FEAT_AW-1:0];

	always_ff @(posedge clk) begin
		if (img_we)
			img_mem[img_wa] <= job.value;
		img_s1 <= img_mem[img_ra];
	end

	always_ff @(posedge clk) begin
		if (feat_we)
			feat_mem[feat_wa] <= job.value;
		feat_s1 <= feat_mem[feat_ra];
	end

	// squared difference stage
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	assign diff = $signed({1'b0, img_s1}) - $signed({1'b0, feat_s1});
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		sq_s2 <= prod[30:0];
	end

	// region divider, shared by the six region and step divides
	logic        rdiv_start, rdiv_done;
	logic [16:0] rdiv_num, rdiv_quo;
	logic [8:0]  rdiv_den, rdiv_rem;

	always_comb begin
		rdiv_num = 17'(by_q - ty_q);
		rdiv_den = 9'(cfg.patch_width);
		unique case (dsel_q)
			3'd0: begin
				rdiv_num = 17'(job_q.cell_y) * 17'(cfg.src_height);
				rdiv_den = cfg.output_width;
			end
			3'd1: begin
				rdiv_num = 17'({1'b0, job_q.cell_y} + 9'd1) * 17'(cfg.src_height);
				rdiv_den = cfg.output_width;
			end
			3'd2: begin
				rdiv_num = 17'(job_q.cell_x) * 17'(cfg.src_width);
				rdiv_den = cfg.output_width;
			end
			3'd3: begin
				rdiv_num = 17'({1'b0, job_q.cell_x} + 9'd1) * 17'(cfg.src_width);
				rdiv_den = cfg.output_width;
			end
			3'd5: rdiv_num = 17'(bx_q - tx_q);
			default: rdiv_num = 17'(by_q - ty_q);
		endcase
	end

	assign rdiv_start = (state_q == S_DSTART);

	pfdm_div #(.NW(17), .DW(9)) u_rdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rdiv_start),
		.num    (rdiv_num),
		.den    (rdiv_den),
		.done   (rdiv_done),
		.quo    (rdiv_quo),
		.rem    (rdiv_rem)
	);

	// mean divider
	logic        mdiv_start, mdiv_done;
	logic [42:0] mdiv_quo;
	logic [12:0] mdiv_rem;

	assign mdiv_start = (state_q == S_MSTART);

	pfdm_div #(.NW(43), .DW(13)) u_mdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mdiv_start),
		.num    (sum_q),
		.den    (fsize_q),
		.done   (mdiv_done),
		.quo    (mdiv_quo),
		.rem    (mdiv_rem)
	);

	// grid stepping
	logic [5:0] nsxr, nsyr;
	logic       sx_c, sy_c, d_last, gx_last, gy_last;
	assign nsxr    = 6'(sxr_q) + 6'(rx_q);
	assign nsyr    = 6'(syr_q) + 6'(ry_q);
	assign sx_c    = nsxr >= 6'(cfg.patch_width);
	assign sy_c    = nsyr >= 6'(cfg.patch_width);
	assign d_last  = 6'(d_q) == 6'(cfg.src_depth) - 6'd1;
	assign gx_last = 6'(gx_q) == 6'(cfg.patch_width) - 6'd1;
	assign gy_last = 6'(gy_q) == 6'(cfg.patch_width) - 6'd1;

	// square root step
	logic [31:0] sq_trial;
	logic        sq_fit;
	logic [15:0] root;
	assign sq_trial = res_q + {1'b0, bit_q};
	assign sq_fit   = {1'b0, v_q} >= sq_trial;
	assign root     = (res_q > 32'(pfdm_pkg::Q_ONE)) ? pfdm_pkg::Q_ONE : res_q[15:0];

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || res_ch.ready);

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop)
			job_q <= job;
		unique case (state_q)
			S_FS1: pw2_q <= 10'(cfg.patch_width) * 10'(cfg.patch_width);
			S_FS2: fsize_q <= 13'(pw2_q) * 13'(cfg.src_depth);
			S_FB: fbase_q <= 19'(job_q.feature_index) * 19'(fsize_q);
			S_DWAIT: begin
				if (rdiv_done) begin
					unique case (dsel_q)
						3'd0: ty_q <= rdiv_quo[8:0];
						3'd1: by_q <= rdiv_quo[8:0];
						3'd2: tx_q <= rdiv_quo[8:0];
						3'd3: bx_q <= rdiv_quo[8:0];
						3'd4: begin
							qy_q <= rdiv_quo[8:0];
							ry_q <= rdiv_rem[4:0];
						end
						default: begin
							qx_q <= rdiv_quo[8:0];
							rx_q <= rdiv_rem[4:0];
						end
					endcase
					if (dsel_q == 3'd5) begin
						gx_q  <= '0;
						gy_q  <= '0;
						sy_q  <= ty_q;
						syr_q <= '0;
						sx_q  <= tx_q;
						sxr_q <= '0;
						fa_q  <= fbase_q;
					end
				end
			end
			S_PA: row_q <= 17'(sy_q) * 17'(cfg.src_width) + 17'(sx_q);
			S_PB: ia_q <= 21'(row_q) * 21'(cfg.src_depth);
			S_PC: d_q <= '0;
			S_RD: begin
				fa_q <= fa_q + 19'd1;
				d_q  <= d_q + DW'(1);
				if (d_last) begin
					if (gx_last) begin
						gx_q  <= '0;
						sx_q  <= tx_q;
						sxr_q <= '0;
						gy_q  <= gy_q + GW'(1);
						sy_q  <= sy_q + qy_q + 9'(sy_c);
						syr_q <= sy_c ? 5'(nsyr - 6'(cfg.patch_width)) : nsyr[4:0];
					end else begin
						gx_q  <= gx_q + GW'(1);
						sx_q  <= sx_q + qx_q + 9'(sx_c);
						sxr_q <= sx_c ? 5'(nsxr - 6'(cfg.patch_width)) : nsxr[4:0];
					end
				end
			end
			S_MWAIT: begin
				if (mdiv_done) begin
					v_q   <= mdiv_quo[30:0];
					res_q <= '0;
					bit_q <= 31'h4000_0000;
				end
			end
			S_SQRT: begin
				if (sq_fit) begin
					v_q   <= 31'({1'b0, v_q} - sq_trial);
					res_q <= (res_q >> 1) + 32'(bit_q);
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
		if (out_load) begin
			out_score_q <= err_q ? 16'd0 : 16'(pfdm_pkg::Q_ONE - root);
			out_err_q   <= err_q;
		end
	end

	// accumulator
	always_ff @(posedge clk) begin
		if ((state_q == S_DWAIT) && rdiv_done && (dsel_q == 3'd5))
			sum_q <= '0;
		else if (sq_v_s2)
			sum_q <= sum_q + 43'(sq_s2);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			err_q       <= 1'b0;
			dsel_q      <= '0;
			sqi_q       <= '0;
			rd_v_s1     <= 1'b0;
			sq_v_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			sq_v_s2 <= rd_v_s1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (res_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (job.kind == pfdm_pkg::K_EVAL) begin
							err_q   <= 1'b0;
							state_q <= S_FS1;
						end else if (job.kind == pfdm_pkg::K_ERR) begin
							err_q   <= 1'b1;
							state_q <= S_OUT;
						end
					end
				end
				S_FS1: state_q <= S_FS2;
				S_FS2: state_q <= S_FB;
				S_FB: state_q <= S_FCHK;
				S_FCHK: begin
					if (32'(fbase_q) + 32'(fsize_q) > 32'(FEATURE_WORDS)) begin
						err_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						dsel_q  <= '0;
						state_q <= S_DSTART;
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (rdiv_done) begin
						dsel_q  <= dsel_q + 3'd1;
						state_q <= (dsel_q == 3'd5) ? S_PA : S_DSTART;
					end
				end
				S_PA: state_q <= S_PB;
				S_PB: state_q <= S_PC;
				S_PC: begin
					if (32'(ia_q) + 32'(cfg.src_depth) > 32'(IMAGE_WORDS)) begin
						err_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (d_last)
						state_q <= (gx_last && gy_last) ? S_DRAIN : S_PA;
				end
				S_DRAIN: begin
					if (!rd_v_s1 && !sq_v_s2)
						state_q <= S_MSTART;
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (mdiv_done) begin
						sqi_q   <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					sqi_q <= sqi_q + 4'd1;
					if (sqi_q == 4'd15)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_ch.valid       = out_valid_q;
	assign res_ch.match_score = out_score_q;
	assign res_ch.range_error = out_err_q;

endmodule

### hdl/patch_feature_distance_map_core.sv
// ----------------------------------------------------------------------------
// patch_feature_distance_map_core: RMS patch template matcher
// Image and feature stores loaded by write commands; an evaluate command
// scores one output cell against one learned feature as 1 - RMS difference.
//
//   channel   dir  handshake        contents
//   cmd_ch    in   valid/ready      command, address, value, cell, feature
//   res_ch    out  valid/ready      match_score, range_error
//   cfg       in   cfg_we           cfg_index, cfg_data (write only)
//
// A write is done in the back end as it is popped; queued writes drain one a cycle while the back end is idle.
// An evaluate runs six 17-step region divides, the grid walk (one store word a
// cycle while reading the depth of a sample), a 43-step mean divide and a 16-step
// square root. The job queue holds four items.
// Reset clears control state only; stores are undefined until written.
// A stalled result holds in the output register while the front still fills.
// ----------------------------------------------------------------------------
module patch_feature_distance_map_core #(
	parameter int IMAGE_WORDS     = 65536,
	parameter int FEATURE_WORDS   = 16384,
	parameter int MAX_PATCH_WIDTH = 16,
	parameter int MAX_DEPTH       = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pfdm_in_if.sink    cmd_ch,
	pfdm_out_if.source res_ch,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);

	pfdm_pkg::cfg_t       cfg_q;
	pfdm_pkg::fifo_stat_t stat;
	pfdm_pkg::job_t       push_job, pop_job;
	logic                 push, pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width     <= 9'd64;
			cfg_q.src_height    <= 9'd64;
			cfg_q.src_depth     <= 5'd3;
			cfg_q.patch_width   <= 5'd5;
			cfg_q.feature_count <= 7'd8;
			cfg_q.output_width  <= 9'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfdm_pkg::CFG_SRC_WIDTH:     cfg_q.src_width     <= cfg_data;
				pfdm_pkg::CFG_SRC_HEIGHT:    cfg_q.src_height    <= cfg_data;
				pfdm_pkg::CFG_SRC_DEPTH:     cfg_q.src_depth     <= cfg_data[4:0];
				pfdm_pkg::CFG_PATCH_WIDTH:   cfg_q.patch_width   <= cfg_data[4:0];
				pfdm_pkg::CFG_FEATURE_COUNT: cfg_q.feature_count <= cfg_data[6:0];
				pfdm_pkg::CFG_OUTPUT_WIDTH:  cfg_q.output_width  <= cfg_data;
				default: ;
			endcase
		end
	end

	pfdm_front #(
		.IMAGE_WORDS     (IMAGE_WORDS),
		.FEATURE_WORDS   (FEATURE_WORDS),
		.MAX_PATCH_WIDTH (MAX_PATCH_WIDTH),
		.MAX_DEPTH       (MAX_DEPTH)
	) u_front (
		.cmd_ch (cmd_ch),
		.cfg    (cfg_q),
		.stat   (stat),
		.push   (push),
		.job    (push_job)
	);

	pfdm_fifo #(.DEPTH(4)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_job),
		.pop    (pop),
		.dout   (pop_job),
		.stat   (stat)
	);

	pfdm_back #(
		.IMAGE_WORDS     (IMAGE_WORDS),
		.FEATURE_WORDS   (FEATURE_WORDS),
		.MAX_PATCH_WIDTH (MAX_PATCH_WIDTH),
		.MAX_DEPTH       (MAX_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.stat   (stat),
		.job    (pop_job),
		.pop    (pop),
		.res_ch (res_ch)
	);

	// checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full)) else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty)) else $error("queue pop while empty");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.range_error |-> res_ch.match_score == 16'd0)
		else $error("error result with nonzero score");

	a_score_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> res_ch.match_score <= pfdm_pkg::Q_ONE)
		else $error("score above one");

endmodule

### dv/patch_feature_distance_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// patch_feature_distance_map_checker: scoreboard for the patch matcher
// Watches the command, result and register ports, keeps its own copy of the
// stores and registers, predicts each result and compares it in order.
// ----------------------------------------------------------------------------
module patch_feature_distance_map_checker (
	input  logic       clk,
	input  logic       arst_n,
	pfdm_in_if         cmd_ch,
	pfdm_out_if        res_ch,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data,
	output int         fail_count,
	output int         pending,
	output int         score_count,
	output int         error_count
);

	localparam int IMG_WORDS  = 65536;
	localparam int FEAT_WORDS = 16384;

	typedef struct packed {
		logic [15:0] score;
		logic        err;
	} match_t;

	match_t         score_q[$];
	logic [15:0]    image_mem [IMG_WORDS];
	logic [15:0]    feature_mem [FEAT_WORDS];
	pfdm_pkg::cfg_t cfg;

	// floor integer square root, one result bit per step
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// score one output cell against one feature
	function automatic match_t score_cell(logic [7:0] cx, logic [7:0] cy, logic [5:0] f);
		longint unsigned iw, ih, dep, pw, fc, ow;
		longint unsigned ty, by, tx, bx, sy, sx;
		longint unsigned fsize, fbase, ia, fa, sum, mean, root;
		longint          diff;
		match_t          r;
		r   = '{score: 16'd0, err: 1'b1};
		iw  = cfg.src_width;
		ih  = cfg.src_height;
		dep = cfg.src_depth;
		pw  = cfg.patch_width;
		fc  = cfg.feature_count;
		ow  = cfg.output_width;
		if (iw < 1 || iw > 256 || ih < 1 || ih > 256) return r;
		if (dep < 1 || dep > 16 || pw < 1 || pw > 16) return r;
		if (fc < 1 || fc > 64 || ow < 1 || ow > 256) return r;
		if (cx >= ow || cy >= ow || f >= fc) return r;
		fsize = pw * pw * dep;
		fbase = f * fsize;
		if (fbase + fsize > FEAT_WORDS) return r;
		ty  = cy * ih / ow;
		by  = (cy + 1) * ih / ow;
		tx  = cx * iw / ow;
		bx  = (cx + 1) * iw / ow;
		sum = 0;
		for (longint unsigned gy = 0; gy < pw; gy++) begin
			sy = ty + gy * (by - ty) / pw;
			for (longint unsigned gx = 0; gx < pw; gx++) begin
				sx = tx + gx * (bx - tx) / pw;
				ia = (sy * iw + sx) * dep;
				fa = fbase + (gy * pw + gx) * dep;
				if (ia + dep > IMG_WORDS) return r;
				for (longint unsigned d = 0; d < dep; d++) begin
					diff = longint'({48'd0, image_mem[ia + d]}) -
						longint'({48'd0, feature_mem[fa + d]});
					sum  = sum + longint'(diff * diff);
				end
			end
		end
		mean = sum / fsize;
		root = floor_sqrt(mean);
		if (root > 32768) root = 32768;
		r.score = 16'(32768 - root);
		r.err   = 1'b0;
		return r;
	endfunction

	// track registers, predict on command transfers, compare result transfers
	always @(posedge clk or negedge arst_n) begin
		logic [15:0] val;
		match_t      got;
		match_t      want;
		int          fails;
		if (!arst_n) begin
			cfg         <= '{src_width: 9'd64, src_height: 9'd64, src_depth: 5'd3,
				patch_width: 5'd5, feature_count: 7'd8, output_width: 9'd16};
			score_q.delete();
			fail_count  <= 0;
			pending     <= 0;
			score_count <= 0;
			error_count <= 0;
		end else begin
			fails = 0;
			if (cfg_we) begin
				case (cfg_index)
					pfdm_pkg::CFG_SRC_WIDTH:     cfg.src_width     <= cfg_data;
					pfdm_pkg::CFG_SRC_HEIGHT:    cfg.src_height    <= cfg_data;
					pfdm_pkg::CFG_SRC_DEPTH:     cfg.src_depth     <= cfg_data[4:0];
					pfdm_pkg::CFG_PATCH_WIDTH:   cfg.patch_width   <= cfg_data[4:0];
					pfdm_pkg::CFG_FEATURE_COUNT: cfg.feature_count <= cfg_data[6:0];
					pfdm_pkg::CFG_OUTPUT_WIDTH:  cfg.output_width  <= cfg_data;
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) begin
				got = '{score: res_ch.match_score, err: res_ch.range_error};
				if (score_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result score=%0d err=%0b", $time,
						got.score, got.err);
				end else begin
					want = score_q.pop_front();
					if (got.score !== want.score) begin
						fails++;
						$display("%0t: match_score expected %0d got %0d", $time,
							want.score, got.score);
					end
					if (got.err !== want.err) begin
						fails++;
						$display("%0t: range_error expected %0b got %0b", $time,
							want.err, got.err);
					end
					if (want.err) error_count <= error_count + 1;
					else score_count <= score_count + 1;
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				val = (cmd_ch.value > 16'd32768) ? 16'd32768 : cmd_ch.value;
				case (pfdm_pkg::cmd_t'(cmd_ch.command))
					pfdm_pkg::CMD_WIMG: image_mem[cmd_ch.address] = val;
					pfdm_pkg::CMD_WFEAT: begin
						if (cmd_ch.address < FEAT_WORDS) feature_mem[cmd_ch.address] = val;
						else score_q.push_back('{score: 16'd0, err: 1'b1});
					end
					pfdm_pkg::CMD_EVAL: score_q.push_back(score_cell(cmd_ch.cell_x,
						cmd_ch.cell_y, cmd_ch.feature_index));
					default: ;
				endcase
			end
			fail_count <= fail_count + fails;
			pending    <= score_q.size();
		end
	end
endmodule

### dv/patch_feature_distance_map_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// patch_feature_distance_map_core_tb: stimulus and verdict
// Loads image and feature stores under a series of register settings, then
// mixes evaluates, overwrites, bad addresses and bad cells, with random
// stalls on both channels; the checker scores every result.
// ----------------------------------------------------------------------------
module patch_feature_distance_map_core_tb;

	localparam int IDLE_LIMIT = 40000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;
	int         fail_count, pending, score_count, error_count;
	int         idle_cycles;
	int         items_sent;
	bit         hold_req;

	pfdm_in_if  cmd_ch ();
	pfdm_out_if res_ch ();

	patch_feature_distance_map_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.res_ch   (res_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	patch_feature_distance_map_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_ch     (cmd_ch),
		.res_ch     (res_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.score_count(score_count),
		.error_count(error_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, calm stretches, one long hold on request
	initial begin
		int r;
		int calm;
		calm = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (2500) @(posedge clk);
			end else if (calm > 0) begin
				calm--;
				res_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					calm = $urandom_range(50, 300);
					res_ch.ready <= 1'b1;
				end else if (r < 62) begin
					res_ch.ready <= 1'b1;
				end else if (r < 95) begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					res_ch.ready <= 1'b0;
					repeat ($urandom_range(20, 80)) @(posedge clk);
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[patch_feature_distance_map_core] ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] rand_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return 16'($urandom_range(0, 32768));
		if (r < 90) return 16'd32768;
		if (r < 95) return 16'd0;
		return 16'($urandom_range(32769, 65535));
	endfunction

	// one command transfer, with a random gap ahead of it
	task automatic send(pfdm_pkg::cmd_t cmd, logic [15:0] addr, logic [15:0] val,
		logic [7:0] cx, logic [7:0] cy, logic [5:0] f);
		int r;
		int gap;
		r   = $urandom_range(0, 99);
		gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.command       <= cmd;
		cmd_ch.address       <= addr;
		cmd_ch.value         <= val;
		cmd_ch.cell_x        <= cx;
		cmd_ch.cell_y        <= cy;
		cmd_ch.feature_index <= f;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
	endtask

	// stop offering and wait until every result is back and writes drained
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_cfg(int iw, int ih, int d, int pw, int fc, int ow);
		write_reg(pfdm_pkg::CFG_SRC_WIDTH, 9'(iw));
		write_reg(pfdm_pkg::CFG_SRC_HEIGHT, 9'(ih));
		write_reg(pfdm_pkg::CFG_SRC_DEPTH, 9'(d));
		write_reg(pfdm_pkg::CFG_PATCH_WIDTH, 9'(pw));
		write_reg(pfdm_pkg::CFG_FEATURE_COUNT, 9'(fc));
		write_reg(pfdm_pkg::CFG_OUTPUT_WIDTH, 9'(ow));
	endtask

	// load both stores over the used region, then a random mix
	task automatic run_phase(int iw, int ih, int d, int pw, int fc, int ow, int n, bit hold);
		int img_words;
		int feat_words;
		int r;
		logic [7:0] cx, cy;
		logic [5:0] f;
		img_words  = iw * ih * d;
		feat_words = fc * pw * pw * d;
		settle();
		write_cfg(iw, ih, d, pw, fc, ow);
		for (int a = 0; a < img_words; a++)
			send(pfdm_pkg::CMD_WIMG, 16'(a), rand_value(), 8'($urandom), 8'($urandom),
				6'($urandom));
		for (int a = 0; a < feat_words; a++)
			send(pfdm_pkg::CMD_WFEAT, 16'(a), rand_value(), 8'($urandom), 8'($urandom),
				6'($urandom));
		if (hold) hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			r  = $urandom_range(0, 99);
			cx = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, ow - 1)) : 8'($urandom);
			cy = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, ow - 1)) : 8'($urandom);
			f  = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, fc - 1)) : 6'($urandom);
			if (r < 62)
				send(pfdm_pkg::CMD_EVAL, 16'($urandom), rand_value(), cx, cy, f);
			else if (r < 74)
				send(pfdm_pkg::CMD_WIMG, 16'($urandom_range(0, img_words - 1)), rand_value(),
					cx, cy, f);
			else if (r < 77)
				send(pfdm_pkg::CMD_WIMG, 16'($urandom), rand_value(), cx, cy, f);
			else if (r < 87)
				send(pfdm_pkg::CMD_WFEAT, 16'($urandom_range(0, feat_words - 1)),
					rand_value(), cx, cy, f);
			else if (r < 93)
				send(pfdm_pkg::CMD_WFEAT, 16'($urandom_range(16384, 65535)), rand_value(),
					cx, cy, f);
			else
				send(pfdm_pkg::CMD_NONE, 16'($urandom), 16'($urandom), cx, cy, f);
		end
	endtask

	// register settings that are out of range: every evaluate must flag
	task automatic bad_cfg(int iw, int ih, int d, int pw, int fc, int ow);
		settle();
		write_cfg(iw, ih, d, pw, fc, ow);
		repeat (2)
			send(pfdm_pkg::CMD_EVAL, 16'($urandom), 16'($urandom), 8'($urandom),
				8'($urandom), 6'($urandom));
	endtask

	initial begin
		cmd_ch.valid         <= 1'b0;
		cmd_ch.command       <= pfdm_pkg::CMD_NONE;
		cmd_ch.address       <= '0;
		cmd_ch.value         <= '0;
		cmd_ch.cell_x        <= '0;
		cmd_ch.cell_y        <= '0;
		cmd_ch.feature_index <= '0;
		cfg_we               <= 1'b0;
		cfg_index            <= pfdm_pkg::CFG_SRC_WIDTH;
		cfg_data             <= '0;
		hold_req             = 1'b0;
		items_sent           = 0;
		arst_n               = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: unused command, bad feature addresses, a clamped image write, bad cells and features
		send(pfdm_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 6'h3F);
		send(pfdm_pkg::CMD_WFEAT, 16'd16384, 16'hFFFF, 8'd0, 8'd0, 6'd0);
		send(pfdm_pkg::CMD_WFEAT, 16'hFFFF, 16'd0, 8'd0, 8'd0, 6'd0);
		send(pfdm_pkg::CMD_WIMG, 16'hFFFF, 16'd32769, 8'd0, 8'd0, 6'd0);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd16, 8'd0, 6'd0);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd0, 8'd255, 6'd0);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd255, 8'd16, 6'd0);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd0, 8'd0, 6'd8);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd3, 8'd3, 6'd63);

		// feature block past the store end, and image rows past the store end
		settle();
		write_cfg(256, 256, 16, 16, 64, 2);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd0, 8'd0, 6'd4);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd1, 8'd0, 6'd63);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd0, 8'd1, 6'd0);
		send(pfdm_pkg::CMD_EVAL, 16'd0, 16'd0, 8'd1, 8'd1, 6'd3);

		// good settings over a range of small and large sizes
		run_phase(8, 8, 2, 3, 4, 4, 100, 1'b1);
		run_phase(1, 1, 1, 1, 1, 1, 40, 1'b0);
		run_phase(256, 1, 1, 4, 2, 256, 120, 1'b0);
		run_phase(1, 16, 1, 16, 1, 1, 20, 1'b0);
		run_phase(2, 2, 16, 2, 3, 2, 100, 1'b0);
		run_phase(6, 5, 1, 1, 64, 256, 80, 1'b0);
		run_phase(3, 7, 4, 2, 5, 5, 80, 1'b0);

		// each register out of range on its own
		bad_cfg(0, 8, 2, 3, 4, 4);
		bad_cfg(257, 8, 2, 3, 4, 4);
		bad_cfg(8, 0, 2, 3, 4, 4);
		bad_cfg(8, 511, 2, 3, 4, 4);
		bad_cfg(8, 8, 0, 3, 4, 4);
		bad_cfg(8, 8, 17, 3, 4, 4);
		bad_cfg(8, 8, 31, 3, 4, 4);
		bad_cfg(8, 8, 2, 0, 4, 4);
		bad_cfg(8, 8, 2, 31, 4, 4);
		bad_cfg(8, 8, 2, 3, 0, 4);
		bad_cfg(8, 8, 2, 3, 127, 4);
		bad_cfg(8, 8, 2, 3, 4, 0);
		bad_cfg(8, 8, 2, 3, 4, 511);

		settle();
		repeat (100) @(posedge clk);
		$display("Sent %0d commands over 7 store layouts and 13 bad register sets;",
			items_sent);
		$display("checked %0d scores and %0d range errors.", score_count, error_count);
		if (fail_count == 0)
			$display("[patch_feature_distance_map_core] OK");
		else
			$display("[patch_feature_distance_map_core] ERROR");
		$finish;
	end
endmodule

### patch_feature_distance_map_core.f
hdl/pfdm_pkg.sv
hdl/pfdm_if.sv
hdl/pfdm_front.sv
hdl/pfdm_fifo.sv
hdl/pfdm_div.sv
hdl/pfdm_back.sv
hdl/patch_feature_distance_map_core.sv
dv/patch_feature_distance_map_checker.sv
dv/patch_feature_distance_map_core_tb.sv
